### rtl/core/dsos_pkg.sv
// Shared constants, codes and types of the disk seek order scheduler.
package dsos_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int CYL_W  = 16;
  localparam int TOT_W  = 22;
  localparam int DISK_W = 17;
  localparam int POL_W  = 3;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [POL_W-1:0] POL_FCFS  = 3'd0;
  localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POL_W-1:0] POL_SCAN  = 3'd2;
  localparam logic [POL_W-1:0] POL_CSCAN = 3'd3;
  localparam logic [POL_W-1:0] POL_LOOK  = 3'd4;
  localparam logic [POL_W-1:0] POL_CLOOK = 3'd5;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK      = 2'd3;

  // Selection rule for one scan pass over the store.
  typedef struct packed {
    logic fcfs;    // take the earliest unserved entry
    logic sstf;    // take the nearest unserved entry
    logic use_hi;  // sweep set: entries at or above the start cylinder
    logic desc;    // sweep order: largest first
  } sel_mode_t;

endpackage

### rtl/core/dsos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/dsos_select.sv
// Shared distance and compare unit: seek distance and candidate test.
module dsos_select (
  input  dsos_pkg::sel_mode_t             mode_i,
  input  logic [dsos_pkg::CYL_W-1:0]      operand_i,
  input  logic [dsos_pkg::CYL_W-1:0]      head_i,
  input  logic [dsos_pkg::CYL_W-1:0]      start_cyl_i,
  input  logic [dsos_pkg::CYL_W-1:0]      best_key_i,
  input  logic                            found_i,
  input  logic                            served_i,
  output logic [dsos_pkg::CYL_W-1:0]      dist_o,
  output logic [dsos_pkg::CYL_W-1:0]      key_o,
  output logic                            better_o
);
  import dsos_pkg::*;

  logic member;

  always_comb begin
    dist_o = (operand_i >= head_i) ? (operand_i - head_i) : (head_i - operand_i);
    if (mode_i.fcfs || mode_i.sstf) begin
      member = 1'b1;
    end else begin
      member = (mode_i.use_hi == (operand_i >= start_cyl_i));
    end
    if (mode_i.fcfs) begin
      key_o = '0;
    end else if (mode_i.sstf) begin
      key_o = dist_o;
    end else if (mode_i.desc) begin
      key_o = ~operand_i;
    end else begin
      key_o = operand_i;
    end
    // strict compare keeps the earliest entry on a tie
    better_o = !served_i && member && (!found_i || (key_o < best_key_i));
  end

endmodule

### rtl/core/disk_seek_order_scheduler.sv
// Disk seek order scheduler: request loading, scan sequencer and result output.
// A request without the last flag is taken and gives no result. The last request starts
// scheduling: each served request costs one scan of the store plus a pick step, and the
// final visit is registered out from the done state.
// Results leave one per strobe; the receiver cannot stall. busy_o drops in the cycle the
// final visit is on the ports.
// Reset clears the count, flags and control state; the store content needs no clearing.
module disk_seek_order_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [dsos_pkg::CYL_W-1:0]        request_cylinder_i,
  input  logic                              last_request_i,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [dsos_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dsos_pkg::DISK_W-1:0]       cfg_data_i,
  // result strobe and payload
  output logic                              valid_o,
  output logic [dsos_pkg::CYL_W-1:0]        visit_cylinder_o,
  output logic [dsos_pkg::KIND_W-1:0]       step_kind_o,
  output logic [dsos_pkg::CYL_W-1:0]        seek_distance_o,
  output logic [dsos_pkg::TOT_W-1:0]        total_movement_o,
  output logic                              batch_overflow_o,
  output logic                              last_visit_o
);
  import dsos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PICK = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // configuration registers
  logic [POL_W-1:0]  policy_q;
  logic              dir_q;
  logic [CYL_W-1:0]  start_cyl_q;
  logic [DISK_W-1:0] disk_q;

  // control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [MAX_REQUESTS-1:0] served_q, served_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              rd_vld_q, rd_vld_d;
  logic              found_q, found_d;
  logic              phase_q, phase_d;
  logic              pref_q, pref_d;
  logic              a_any_q, a_any_d;
  logic              a_nz_q, a_nz_d;
  logic              pend_vld_q, pend_vld_d;
  logic              out_vld_q, out_vld_d;

  // payload registers
  logic [IDX_W-1:0]  rd_idx_q;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [CYL_W-1:0]  best_val_q, best_val_d;
  logic [CYL_W-1:0]  best_key_q, best_key_d;
  logic [CYL_W-1:0]  head_q, head_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [CYL_W-1:0]  pend_cyl_q, pend_cyl_d;
  logic [KIND_W-1:0] pend_kind_q, pend_kind_d;
  logic [CYL_W-1:0]  pend_dist_q, pend_dist_d;
  logic [TOT_W-1:0]  pend_tot_q, pend_tot_d;
  logic [CYL_W-1:0]  out_cyl_q, out_cyl_d;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;
  logic [CYL_W-1:0]  out_dist_q, out_dist_d;
  logic [TOT_W-1:0]  out_tot_q, out_tot_d;
  logic              out_ovf_q, out_ovf_d;
  logic              out_last_q, out_last_d;

  // datapath wires
  logic              accept;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [CYL_W-1:0]  ram_rdata;
  logic [DISK_W-1:0] disk_m1;
  logic [CYL_W-1:0]  top_cyl;
  logic              is_sweep, is_cscan, is_clook, has_mid;
  sel_mode_t         mode;
  logic [CYL_W-1:0]  sel_operand;
  logic [CYL_W-1:0]  sel_dist;
  logic [CYL_W-1:0]  sel_key;
  logic              sel_better;
  logic              push;
  logic [CYL_W-1:0]  push_val;
  logic [KIND_W-1:0] push_kind;
  logic              mid_cond;

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q != S_IDLE);
  assign ram_we    = accept && (cnt_q < CNT_W'(MAX_REQUESTS));
  assign ram_raddr = iss_q[IDX_W-1:0];

  dsos_ram #(
    .WIDTH (CYL_W),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (request_cylinder_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // top end: size zero maps to 0, oversize saturates
  assign disk_m1 = disk_q - DISK_W'(1);
  always_comb begin
    if (disk_q == '0) begin
      top_cyl = '0;
    end else if (disk_m1[DISK_W-1]) begin
      top_cyl = '1;
    end else begin
      top_cyl = disk_m1[CYL_W-1:0];
    end
  end

  // policy decode; unused codes fall back to arrival order
  assign is_cscan = (policy_q == POL_CSCAN);
  assign is_clook = (policy_q == POL_CLOOK);
  assign has_mid  = (policy_q == POL_SCAN) || is_cscan;
  assign is_sweep = has_mid || (policy_q == POL_LOOK) || is_clook;

  // phase A sweeps away from the start in the chosen direction; phase B covers the rest
  always_comb begin
    mode.sstf   = (policy_q == POL_SSTF);
    mode.fcfs   = !mode.sstf && !is_sweep;
    mode.use_hi = phase_q ? dir_q : !dir_q;
    if (!phase_q) begin
      mode.desc = dir_q;
    end else if (is_cscan || is_clook) begin
      mode.desc = dir_q;
    end else begin
      mode.desc = !dir_q;
    end
  end

  // up: end point unless the upper set was empty or already reached the top;
  // down: cylinder 0 unless the lower set was all zero
  assign mid_cond = dir_q ? a_nz_q : (a_any_q && (head_q != top_cyl));

  // the unit measures candidates while scanning and the seek distance on a push
  assign sel_operand = (state_q == S_PICK) ? push_val : ram_rdata;

  dsos_select u_select (
    .mode_i      (mode),
    .operand_i   (sel_operand),
    .head_i      (head_q),
    .start_cyl_i (start_cyl_q),
    .best_key_i  (best_key_q),
    .found_i     (found_q),
    .served_i    (served_q[rd_idx_q]),
    .dist_o      (sel_dist),
    .key_o       (sel_key),
    .better_o    (sel_better)
  );

  // choose what, if anything, the pick step pushes
  always_comb begin
    push      = 1'b0;
    push_val  = best_val_q;
    push_kind = KIND_SERVE;
    if (state_q == S_PICK) begin
      if (found_q) begin
        push = 1'b1;
        if (phase_q && is_cscan && !pref_q) begin
          push_val  = dir_q ? top_cyl : '0;
          push_kind = KIND_END;
        end
      end else if (!phase_q && is_sweep && has_mid && mid_cond) begin
        push      = 1'b1;
        push_val  = dir_q ? '0 : top_cyl;
        push_kind = KIND_END;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    served_d    = served_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    phase_d     = phase_q;
    pref_d      = pref_q;
    a_any_d     = a_any_q;
    a_nz_d      = a_nz_q;
    pend_vld_d  = pend_vld_q;
    out_vld_d   = 1'b0;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    best_key_d  = best_key_q;
    head_d      = head_q;
    total_d     = total_q;
    pend_cyl_d  = pend_cyl_q;
    pend_kind_d = pend_kind_q;
    pend_dist_d = pend_dist_q;
    pend_tot_d  = pend_tot_q;
    out_cyl_d   = out_cyl_q;
    out_kind_d  = out_kind_q;
    out_dist_d  = out_dist_q;
    out_tot_d   = out_tot_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;

    // a push releases the held result and holds the new one, so the final
    // visit is known when the batch ends
    if (push) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_cyl_d  = pend_cyl_q;
        out_kind_d = pend_kind_q;
        out_dist_d = pend_dist_q;
        out_tot_d  = pend_tot_q;
        out_ovf_d  = ovf_q;
        out_last_d = 1'b0;
      end
      pend_vld_d  = 1'b1;
      pend_cyl_d  = push_val;
      pend_kind_d = push_kind;
      pend_dist_d = sel_dist;
      pend_tot_d  = total_q + TOT_W'(sel_dist);
      total_d     = total_q + TOT_W'(sel_dist);
      head_d      = push_val;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cnt_q < CNT_W'(MAX_REQUESTS)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_request_i) begin
            // hold the start position as the first result
            pend_vld_d  = 1'b1;
            pend_cyl_d  = start_cyl_q;
            pend_kind_d = KIND_START;
            pend_dist_d = '0;
            pend_tot_d  = '0;
            head_d      = start_cyl_q;
            total_d     = '0;
            served_d    = '0;
            phase_d     = 1'b0;
            pref_d      = 1'b0;
            a_any_d     = 1'b0;
            a_nz_d      = 1'b0;
            iss_d       = '0;
            found_d     = 1'b0;
            state_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_q < cnt_q) begin
          iss_d    = iss_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && sel_better) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_val_d = ram_rdata;
          best_key_d = sel_key;
        end
        if ((iss_q == cnt_q) && !rd_vld_q) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (found_q) begin
          if (phase_q && is_cscan && !pref_q) begin
            // end point before the wrapped set; keep the candidate
            pref_d = 1'b1;
          end else begin
            served_d[best_idx_q] = 1'b1;
            if (!phase_q) begin
              a_any_d = 1'b1;
              a_nz_d  = a_nz_q || (best_val_q != '0);
            end
            iss_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end else if (!phase_q && is_sweep) begin
          phase_d = 1'b1;
          iss_d   = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // flush the held result as the final visit and drop the batch
        out_vld_d  = 1'b1;
        out_cyl_d  = pend_cyl_q;
        out_kind_d = pend_kind_q;
        out_dist_d = pend_dist_q;
        out_tot_d  = pend_tot_q;
        out_ovf_d  = ovf_q;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
        cnt_d      = '0;
        ovf_d      = 1'b0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POL_FCFS;
      dir_q       <= 1'b0;
      start_cyl_q <= '0;
      disk_q      <= DISK_W'(200);
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      served_q    <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      phase_q     <= 1'b0;
      pref_q      <= 1'b0;
      a_any_q     <= 1'b0;
      a_nz_q      <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      head_q      <= '0;
      total_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLICY:    policy_q    <= cfg_data_i[POL_W-1:0];
          CFG_DIRECTION: dir_q       <= cfg_data_i[0];
          CFG_START:     start_cyl_q <= cfg_data_i[CYL_W-1:0];
          CFG_DISK:      disk_q      <= cfg_data_i;
          default:       disk_q      <= disk_q;
        endcase
      end
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      served_q   <= served_d;
      iss_q      <= iss_d;
      rd_vld_q   <= rd_vld_d;
      found_q    <= found_d;
      phase_q    <= phase_d;
      pref_q     <= pref_d;
      a_any_q    <= a_any_d;
      a_nz_q     <= a_nz_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      head_q     <= head_d;
      total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= ram_raddr;
    best_idx_q  <= best_idx_d;
    best_val_q  <= best_val_d;
    best_key_q  <= best_key_d;
    pend_cyl_q  <= pend_cyl_d;
    pend_kind_q <= pend_kind_d;
    pend_dist_q <= pend_dist_d;
    pend_tot_q  <= pend_tot_d;
    out_cyl_q   <= out_cyl_d;
    out_kind_q  <= out_kind_d;
    out_dist_q  <= out_dist_d;
    out_tot_q   <= out_tot_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign valid_o          = out_vld_q;
  assign visit_cylinder_o = out_cyl_q;
  assign step_kind_o      = out_kind_q;
  assign seek_distance_o  = out_dist_q;
  assign total_movement_o = out_tot_q;
  assign batch_overflow_o = out_ovf_q;
  assign last_visit_o     = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_visit_o) |-> busy_o)
    else $error("non-final visit emitted while idle");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_visit_o) |=> !valid_o)
    else $error("visit emitted right after final visit");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (step_kind_o == KIND_START)) |-> (seek_distance_o == '0 &&
      total_movement_o == '0))
    else $error("start visit carries movement");

endmodule

### bench/disk_seek_order_scheduler_tb.sv
// Self-checking bench for the disk seek order scheduler with a visit-order predictor.
module disk_seek_order_scheduler_tb;
  import dsos_pkg::*;

  typedef struct {
    logic [CYL_W-1:0]  cyl;
    logic [KIND_W-1:0] kind;
    logic [CYL_W-1:0]  seek;
    logic [TOT_W-1:0]  total;
    logic              ovf;
    logic              last;
  } visit_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Predict the visit order of each batch and check results against it.
  class visit_scoreboard;
    logic [CYL_W-1:0]  batch_cyl[$];
    logic              batch_ovf;
    logic [POL_W-1:0]  policy;
    logic              dir_down;
    logic [CYL_W-1:0]  start_cyl;
    logic [DISK_W-1:0] disk_size;
    visit_t            pending_visits[$];
    int                batches_done;
    logic [CYL_W-1:0]  order[$];
    logic [KIND_W-1:0] kinds[$];

    function new();
      policy = POL_FCFS; dir_down = 0; start_cyl = 0; disk_size = 200;
      batch_ovf = 0; batches_done = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DISK_W-1:0] val);
      case (idx)
        CFG_POLICY:    policy = val[POL_W-1:0];
        CFG_DIRECTION: dir_down = val[0];
        CFG_START:     start_cyl = val[CYL_W-1:0];
        default:       disk_size = val;
      endcase
    endfunction

    function void add_visit(logic [CYL_W-1:0] cyl, logic [KIND_W-1:0] kind);
      order.insert(order.size(), cyl);
      kinds.insert(kinds.size(), kind);
    endfunction

    function void schedule_batch();
      logic [CYL_W-1:0] lower[$], upper[$];
      logic [CYL_W-1:0] top_end;
      logic [CYL_W-1:0] head;
      logic [CYL_W-1:0] step_len;
      logic [TOT_W-1:0] total;
      bit               taken[$];
      bit               sweep;
      int               pick;
      int               n;
      visit_t           v;
      n = batch_cyl.size();
      order.delete(); kinds.delete();
      top_end = (disk_size == 0) ? '0 :
                (disk_size > 65536) ? 16'hFFFF : CYL_W'(disk_size - 1);
      add_visit(start_cyl, KIND_START);
      sweep = policy inside {POL_SCAN, POL_CSCAN, POL_LOOK, POL_CLOOK};
      if (policy == POL_SSTF) begin
        head = start_cyl;
        for (int i = 0; i < n; i++) taken.insert(taken.size(), 1'b0);
        for (int k = 0; k < n; k++) begin
          pick = -1;
          for (int i = 0; i < n; i++)
            if (!taken[i] && (pick < 0 || absd(batch_cyl[i], head) < absd(batch_cyl[pick], head)))
              pick = i;
          taken[pick] = 1; head = batch_cyl[pick];
          add_visit(head, KIND_SERVE);
        end
      end else if (!sweep) begin
        foreach (batch_cyl[i]) add_visit(batch_cyl[i], KIND_SERVE);
      end else begin
        foreach (batch_cyl[i])
          if (batch_cyl[i] < start_cyl) lower.insert(lower.size(), batch_cyl[i]);
          else upper.insert(upper.size(), batch_cyl[i]);
        lower.sort(); upper.sort();
        if (!dir_down) begin
          foreach (upper[i]) add_visit(upper[i], KIND_SERVE);
          if ((policy == POL_SCAN || policy == POL_CSCAN) && upper.size() > 0 &&
              upper[$] != top_end) begin
            add_visit(top_end, KIND_END);
          end
          if (policy == POL_SCAN || policy == POL_LOOK) begin
            for (int i = lower.size() - 1; i >= 0; i--) add_visit(lower[i], KIND_SERVE);
          end else begin
            if (policy == POL_CSCAN && lower.size() > 0) add_visit('0, KIND_END);
            foreach (lower[i]) add_visit(lower[i], KIND_SERVE);
          end
        end else begin
          for (int i = lower.size() - 1; i >= 0; i--) add_visit(lower[i], KIND_SERVE);
          if ((policy == POL_SCAN || policy == POL_CSCAN) && lower.size() > 0 && lower[$] != 0)
          begin
            add_visit('0, KIND_END);
          end
          if (policy == POL_SCAN || policy == POL_LOOK) begin
            foreach (upper[i]) add_visit(upper[i], KIND_SERVE);
          end else begin
            if (policy == POL_CSCAN && upper.size() > 0) add_visit(top_end, KIND_END);
            for (int i = upper.size() - 1; i >= 0; i--) add_visit(upper[i], KIND_SERVE);
          end
        end
      end
      head = start_cyl; total = 0;
      foreach (order[k]) begin
        step_len = absd(order[k], head);
        total = total + TOT_W'(step_len);
        head = order[k];
        v.cyl = order[k]; v.kind = kinds[k]; v.seek = step_len; v.total = total;
        v.ovf = batch_ovf; v.last = (k == order.size() - 1);
        pending_visits.insert(pending_visits.size(), v);
      end
      batch_cyl.delete(); batch_ovf = 0; batches_done++;
    endfunction

    function logic [CYL_W-1:0] absd(logic [CYL_W-1:0] a, logic [CYL_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void note_request(logic [CYL_W-1:0] cyl, logic last);
      if (batch_cyl.size() < MAX_REQUESTS) batch_cyl.insert(batch_cyl.size(), cyl);
      else batch_ovf = 1;
      if (last) schedule_batch();
    endfunction

    task check_visit(visit_t got);
      visit_t want;
      if (pending_visits.size() == 0) begin
        report_mismatch("unexpected visit cylinder", got.cyl, -1);
      end else begin
        want = pending_visits.pop_front();
        if (got.cyl !== want.cyl)     report_mismatch("visit_cylinder", got.cyl, want.cyl);
        if (got.kind !== want.kind)   report_mismatch("step_kind", got.kind, want.kind);
        if (got.seek !== want.seek)   report_mismatch("seek_distance", got.seek, want.seek);
        if (got.total !== want.total) report_mismatch("total_movement", got.total, want.total);
        if (got.ovf !== want.ovf)     report_mismatch("batch_overflow", got.ovf, want.ovf);
        if (got.last !== want.last)   report_mismatch("last_visit", got.last, want.last);
      end
    endtask
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              start_i = 0;
  logic              busy_o;
  logic [CYL_W-1:0]  request_cylinder_i = '0;
  logic              last_request_i = 0;
  logic              cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DISK_W-1:0] cfg_data_i = '0;
  logic              valid_o;
  logic [CYL_W-1:0]  visit_cylinder_o;
  logic [KIND_W-1:0] step_kind_o;
  logic [CYL_W-1:0]  seek_distance_o;
  logic [TOT_W-1:0]  total_movement_o;
  logic              batch_overflow_o;
  logic              last_visit_o;

  visit_scoreboard sb = new();
  int  cycle_count = 0;
  bit  quiet_tail = 0;
  localparam int CYCLE_LIMIT = 2_000_000;

  disk_seek_order_scheduler u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check every strobed visit; stop the run if it hangs.
  always @(posedge clk_i) begin
    visit_t got;
    cycle_count++;
    if (rst_ni && valid_o) begin
      got.cyl = visit_cylinder_o; got.kind = step_kind_o; got.seek = seek_distance_o;
      got.total = total_movement_o; got.ovf = batch_overflow_o; got.last = last_visit_o;
      sb.check_visit(got);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[disk_seek_order_scheduler] ERROR");
      $finish;
    end
  end

  // Hold the sender off for a random burst now and then.
  task automatic maybe_idle();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      start_i <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
  endtask

  // Drive one request and wait for the handshake; start stays high for the next one.
  task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
    maybe_idle();
    start_i <= 1; request_cylinder_i <= cyl; last_request_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(cyl, last);
    @(negedge clk_i);
  endtask

  // Drop start, wait until every predicted visit is out, plus a margin.
  task automatic drain();
    start_i <= 0;
    while (sb.pending_visits.size() != 0) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DISK_W-1:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_mode(input logic [POL_W-1:0] pol, input logic dir,
                          input logic [CYL_W-1:0] st, input logic [DISK_W-1:0] disk);
    write_reg(CFG_POLICY, DISK_W'(pol));
    write_reg(CFG_DIRECTION, DISK_W'(dir));
    write_reg(CFG_START, DISK_W'(st));
    write_reg(CFG_DISK, disk);
    cfg_we_i <= 0;
  endtask

  // One batch of random requests, mostly within the disk size.
  task automatic random_batch(input int n, input logic [DISK_W-1:0] disk);
    logic [CYL_W-1:0] cyl;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: cyl = CYL_W'($urandom);
        1: cyl = (disk == 0) ? '0 : CYL_W'(disk - 1);
        2: cyl = sb.start_cyl;
        default: cyl = (disk > 1) ? CYL_W'($urandom_range(0, disk - 1)) : '0;
      endcase
      send_request(cyl, i == n - 1);
    end
  endtask

  initial begin
    logic [DISK_W-1:0] disk;
    int                sent;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: reset config FCFS, extremes of the cylinder field.
    send_request(16'h0000, 0);
    send_request(16'hFFFF, 0);
    send_request(16'd199, 1);
    drain();
    // Each policy code both ways, with a request beyond the top end.
    for (int p = 0; p < 8; p++) begin
      for (int d = 0; d < 2; d++) begin
        set_mode(p[POL_W-1:0], d[0], 16'd100, 17'd200);
        send_request(16'd150, 0);
        send_request(16'd50, 0);
        send_request(16'd100, 0);
        send_request(16'd250, 1);
        drain();
      end
    end
    // Zero-size and oversize disks; single-request batch.
    set_mode(POL_CSCAN, 0, 16'd10, 17'd0);
    send_request(16'd5, 0); send_request(16'd20, 1);
    drain();
    set_mode(POL_SCAN, 1, 16'hFFFF, 17'h1FFFF);
    send_request(16'd1, 1);
    drain();
    // SSTF ties broken by arrival order.
    set_mode(POL_SSTF, 0, 16'd100, 17'd65536);
    send_request(16'd110, 0); send_request(16'd90, 0); send_request(16'd100, 1);
    drain();
    // Overflow: fill the store beyond capacity.
    set_mode(POL_LOOK, 0, 16'd32768, 17'd65536);
    random_batch(MAX_REQUESTS + 3, 17'd65536);
    // Pause until every visit is out before the random part.
    drain();

    sent = 0;
    while (sent < 55) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
      if (sent > 40) quiet_tail = 1;
      case ($urandom_range(0, 3))
        0: disk = 17'd200;
        1: disk = 17'd65536;
        2: disk = DISK_W'($urandom_range(1, 70000));
        default: disk = DISK_W'($urandom_range(0, 20));
      endcase
      set_mode(POL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
               ($urandom_range(0, 3) == 0) ? 16'hFFFF : CYL_W'($urandom_range(0, 300)),
               disk);
      random_batch(n, disk);
      sent += n;
      if ($urandom_range(0, 1)) drain();
      else begin
        start_i <= 0;
        while (sb.pending_visits.size() != 0 || busy_o) @(negedge clk_i);
      end
      drain();
    end

    drain();
    if (error_count == 0 && sb.pending_visits.size() == 0) begin
      $display("[disk_seek_order_scheduler] OK");
    end else begin
      $display("[disk_seek_order_scheduler] ERROR");
    end
    $finish;
  end
endmodule

### disk_seek_order_scheduler.f
rtl/core/dsos_pkg.sv
rtl/core/dsos_ram.sv
rtl/core/dsos_select.sv
rtl/core/disk_seek_order_scheduler.sv
bench/disk_seek_order_scheduler_tb.sv
